// File: hw/rtl/lbs_pkg.sv
// shared types and constants for the leftmost binary search core
// no dependencies
`default_nettype none

package lbs_pkg;

	localparam int INDEX_W   = 10;
	localparam int KEY_IN_W  = 32;
	localparam int COUNT_W   = 11;
	localparam int CFG_IDX_W = 2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// input kind codes
	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_SIGNED = 2'd1;

	typedef enum logic {
		OP_WRITE,
		OP_SEARCH
	} op_t;

	// one classified item as it sits in the queue
	typedef struct packed {
		op_t                 op;
		logic [INDEX_W-1:0]  entry_index;
		logic [KEY_IN_W-1:0] data;
	} item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] entry_count;
		logic               compare_signed;
	} cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/lbs_front.sv
// front end: takes commands, drops writes outside the table, classifies the rest
// depends on lbs_pkg
`default_nettype none

module lbs_front import lbs_pkg::*; #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic                start,
	input  wire logic                q_full,
	input  wire logic                kind,
	input  wire logic [INDEX_W-1:0]  entry_index,
	input  wire logic [KEY_IN_W-1:0] entry_value,
	input  wire logic [KEY_IN_W-1:0] search_key,
	output      logic                busy,
	output      logic                push,
	output      item_t               push_item
);

	localparam int CMP_W = ($clog2(TABLE_DEPTH + 1) > INDEX_W + 1) ?
		$clog2(TABLE_DEPTH + 1) : INDEX_W + 1;
	localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_DEPTH);

	logic accept;
	logic in_range;

	assign busy     = q_full;
	assign accept   = start && !q_full;
	assign in_range = CMP_W'(entry_index) < DEPTH_C;

	always_comb begin
		push_item.entry_index = entry_index;
		if (kind == KIND_SEARCH) begin
			push_item.op   = OP_SEARCH;
			push_item.data = search_key;
			push           = accept;
		end else begin
			push_item.op   = OP_WRITE;
			push_item.data = entry_value;
			// out of range writes are dropped here
			push           = accept && in_range;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/lbs_queue.sv
// small queue between front and back end
// depends on lbs_pkg
`default_nettype none

module lbs_queue import lbs_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	input  wire logic  pop,
	output      item_t head,
	output      logic  full,
	output      logic  empty
);

	item_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_item;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("push did not grow queue");

endmodule

`default_nettype wire

// File: hw/rtl/lbs_back.sv
// back end: key table memory and the halving search sequencer
// depends on lbs_pkg
`default_nettype none

module lbs_back import lbs_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_WIDTH   = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire item_t              q_head,
	input  wire logic               q_empty,
	output      logic               pop,
	output      logic               done,
	output      logic               found,
	output      logic [INDEX_W-1:0] found_index
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
	localparam logic [CMP_W-1:0]     DEPTH_C  = CMP_W'(TABLE_DEPTH);
	localparam logic [KEY_WIDTH-1:0] SIGN_BIT = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	state_t               state_q;
	logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];
	logic [KEY_WIDTH-1:0] rd_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [CNT_W-1:0]     lo_q, hi_q, mid_q, hit_q;
	logic                 hit_valid_q;
	logic                 done_q, found_q;
	logic [INDEX_W-1:0]   found_index_q;

	logic [63:0]          data_ext;
	logic [KEY_WIDTH-1:0] head_key;
	logic [CMP_W-1:0]     count_ext;
	logic [CMP_W-1:0]     hi_clamp_ext;
	logic [KEY_WIDTH-1:0] want, have;
	logic                 mem_we, rd_en, searching, finish, go;
	logic [CNT_W-1:0]     nlo, nhi, nmid, nhit;
	logic                 nfound;
	logic [CMP_W-1:0]     hit_ext;

	// low key bits of the 32-bit field, zero above it for wide keys
	assign data_ext     = {32'd0, q_head.data};
	assign head_key     = data_ext[KEY_WIDTH-1:0];
	assign count_ext    = CMP_W'(cfg.entry_count);
	assign hi_clamp_ext = (count_ext > DEPTH_C) ? DEPTH_C : count_ext;

	// flipping the sign bit turns signed order into unsigned order
	assign want = key_q ^ (cfg.compare_signed ? SIGN_BIT : '0);
	assign have = rd_q  ^ (cfg.compare_signed ? SIGN_BIT : '0);

	always_comb begin
		pop       = 1'b0;
		mem_we    = 1'b0;
		searching = 1'b0;
		nlo       = lo_q;
		nhi       = hi_q;
		nfound    = hit_valid_q;
		nhit      = hit_q;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					if (q_head.op == OP_WRITE) begin
						mem_we = 1'b1;
					end else begin
						searching = 1'b1;
						nlo       = '0;
						nhi       = hi_clamp_ext[CNT_W-1:0];
						nfound    = 1'b0;
						nhit      = '0;
					end
				end
			end
			ST_SEARCH: begin
				searching = 1'b1;
				if (want > have) begin
					nlo = mid_q + 1'b1;
				end else begin
					if (want == have) begin
						nfound = 1'b1;
						nhit   = mid_q;
					end
					nhi = mid_q;
				end
			end
			default: begin
				searching = 1'b0;
			end
		endcase
		go      = nlo < nhi;
		nmid    = nlo + ((nhi - nlo) >> 1);
		rd_en   = searching && go;
		finish  = searching && !go;
		hit_ext = CMP_W'(nhit);
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[IDX_W'(q_head.entry_index)] <= head_key;
		if (rd_en)
			rd_q <= mem[nmid[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (pop && q_head.op == OP_SEARCH)
			key_q <= head_key;
		if (searching) begin
			lo_q        <= nlo;
			hi_q        <= nhi;
			mid_q       <= nmid;
			hit_q       <= nhit;
			hit_valid_q <= nfound;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			done_q        <= 1'b0;
			found_q       <= 1'b0;
			found_index_q <= '0;
		end else begin
			done_q <= finish;
			if (finish) begin
				state_q       <= ST_IDLE;
				found_q       <= nfound;
				found_index_q <= nfound ? hit_ext[INDEX_W-1:0] : '0;
			end else if (searching) begin
				state_q <= ST_SEARCH;
			end
		end
	end

	assign done        = done_q;
	assign found       = found_q;
	assign found_index = found_index_q;

	a_probe_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEARCH |-> lo_q <= mid_q && mid_q < hi_q)
		else $error("probe outside search window");

	a_search_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_SEARCH) |-> $past(pop))
		else $error("search started without a queue pop");

	a_miss_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !found_q |-> found_index_q == '0)
		else $error("miss reported with nonzero index");

endmodule

`default_nettype wire

// File: hw/rtl/leftmost_binary_search_core.sv
// leftmost binary search core: config registers, front end, queue, back end
// depends on lbs_pkg, lbs_front, lbs_queue, lbs_back
//
// channel   | signals                                          | handshake
// ----------+--------------------------------------------------+------------------------
// command   | kind, entry_index, entry_value, search_key       | start && !busy
// result    | found, found_index                               | done strobe, one cycle
// config    | cfg_index, cfg_wdata                             | cfg_wr_en, no wait
//
// a write is stored in the table as it is popped; a search pops its command and
// then makes halving steps, at most floor(log2(n)) + 1 for n entries in use, with
// no new pop until it is done: each step is one read of the single table port
// the result strobe rises in the cycle after the last compare, or in the cycle after
// the pop when no entries are in use
// busy is high while the two-entry command queue is full
// results cannot be stalled; reset clears control state, the table is
// undefined until written
`default_nettype none

module leftmost_binary_search_core import lbs_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_WIDTH   = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output      logic                 busy,
	input  wire logic                 kind,
	input  wire logic [INDEX_W-1:0]   entry_index,
	input  wire logic [KEY_IN_W-1:0]  entry_value,
	input  wire logic [KEY_IN_W-1:0]  search_key,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COUNT_W-1:0]   cfg_wdata,
	output      logic                 done,
	output      logic                 found,
	output      logic [INDEX_W-1:0]   found_index
);

	cfg_t  cfg_q;
	logic  push, pop, q_full, q_empty;
	item_t push_item, q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_ENTRY_COUNT:    cfg_q.entry_count    <= cfg_wdata;
				CFG_COMPARE_SIGNED: cfg_q.compare_signed <= cfg_wdata[0];
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	lbs_front #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_front (
		.start      (start),
		.q_full     (q_full),
		.kind       (kind),
		.entry_index(entry_index),
		.entry_value(entry_value),
		.search_key (search_key),
		.busy       (busy),
		.push       (push),
		.push_item  (push_item)
	);

	lbs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head     (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	lbs_back #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.KEY_WIDTH  (KEY_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_head     (q_head),
		.q_empty    (q_empty),
		.pop        (pop),
		.done       (done),
		.found      (found),
		.found_index(found_index)
	);

endmodule

`default_nettype wire

// File: dv/lbs_checker.sv
// result checker for the leftmost binary search core: mirrors the key table
// and configuration, predicts each search, compares the result transfers
// depends on lbs_pkg
`timescale 1ns / 1ps

module lbs_checker import lbs_pkg::*; #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic                 kind,
	input  logic [INDEX_W-1:0]   entry_index,
	input  logic [KEY_IN_W-1:0]  entry_value,
	input  logic [KEY_IN_W-1:0]  search_key,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COUNT_W-1:0]   cfg_wdata,
	input  logic                 done,
	input  logic                 found,
	input  logic [INDEX_W-1:0]   found_index,
	output int                   mismatches,
	output int                   lookups_pending
);

	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] index;
	} lookup_t;

	localparam logic [KEY_IN_W-1:0] SIGN_BIT = {1'b1, {(KEY_IN_W-1){1'b0}}};

	logic [KEY_IN_W-1:0] key_mirror [TABLE_DEPTH];
	cfg_t                cfg_mirror;
	lookup_t             pending_lookups [$];
	int                  error_total = 0;

	// flipping the sign bit makes signed order match unsigned order
	function automatic logic [KEY_IN_W-1:0] order_rank(logic [KEY_IN_W-1:0] k);
		return cfg_mirror.compare_signed ? (k ^ SIGN_BIT) : k;
	endfunction

	function automatic lookup_t lower_bound_lookup(logic [KEY_IN_W-1:0] key);
		lookup_t             res;
		logic [KEY_IN_W-1:0] want;
		logic [KEY_IN_W-1:0] have;
		int                  lo;
		int                  hi;
		int                  mid;
		res  = '0;
		want = order_rank(key);
		lo   = 0;
		hi   = (cfg_mirror.entry_count > TABLE_DEPTH) ? TABLE_DEPTH
		                                              : int'(cfg_mirror.entry_count);
		while (lo < hi) begin
			mid  = lo + ((hi - lo) >> 1);
			have = order_rank(key_mirror[mid[INDEX_W-1:0]]);
			if (want > have) begin
				lo = mid + 1;
			end else begin
				// keep narrowing left after a hit so duplicates give the first index
				if (want == have) begin
					res.found = 1'b1;
					res.index = mid[INDEX_W-1:0];
				end
				hi = mid;
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		lookup_t expected;
		if (!arst_n) begin
			cfg_mirror = '0;
			pending_lookups.delete();
			lookups_pending <= 0;
		end else begin
			if (done) begin
				if (pending_lookups.size() == 0) begin
					$error("result transfer with no search outstanding");
					error_total++;
				end else begin
					expected = pending_lookups.pop_front();
					if (found !== expected.found) begin
						$error("found: expected %0d, actual %0d", expected.found, found);
						error_total++;
					end
					if (found_index !== expected.index) begin
						$error("found_index: expected %0d, actual %0d",
							expected.index, found_index);
						error_total++;
					end
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_ENTRY_COUNT:    cfg_mirror.entry_count = cfg_wdata;
					CFG_COMPARE_SIGNED: cfg_mirror.compare_signed = cfg_wdata[0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (kind == KIND_SEARCH) begin
					pending_lookups.push_back(lower_bound_lookup(search_key));
				end else begin
					key_mirror[entry_index] = entry_value;
				end
			end
			lookups_pending <= pending_lookups.size();
		end
		mismatches <= error_total;
	end

endmodule

// File: dv/leftmost_binary_search_core_test.sv
// testbench top for the leftmost binary search core: directed and random
// table loads and searches with random gaps, verdict from lbs_checker
// depends on lbs_pkg, leftmost_binary_search_core, lbs_checker
`timescale 1ns / 1ps

module leftmost_binary_search_core_test;
	import lbs_pkg::*;

	localparam int TABLE_DEPTH   = 1024;
	localparam int TOTAL_ITEMS   = 1450;
	localparam int IDLE_LIMIT    = 1000;
	localparam int SETTLE_CYCLES = 20;

	// register indexes past the two real registers
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	localparam logic [KEY_IN_W-1:0] SIGN_BIT = 32'h8000_0000;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 start       = 1'b0;
	logic                 kind        = KIND_WRITE;
	logic [INDEX_W-1:0]   entry_index = '0;
	logic [KEY_IN_W-1:0]  entry_value = '0;
	logic [KEY_IN_W-1:0]  search_key  = '0;
	logic                 cfg_wr_en   = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [COUNT_W-1:0]   cfg_wdata   = '0;
	logic                 busy;
	logic                 done;
	logic                 found;
	logic [INDEX_W-1:0]   found_index;

	int mismatches;
	int lookups_pending;
	int idle_cycles = 0;
	int items_sent  = 0;
	bit gaps_on     = 1'b1;
	bit signed_order;
	int loaded_count = 0;

	logic [KEY_IN_W-1:0] loaded_keys [TABLE_DEPTH];

	always #5 clk = ~clk;

	leftmost_binary_search_core #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.KEY_WIDTH  (KEY_IN_W)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.entry_index(entry_index),
		.entry_value(entry_value),
		.search_key (search_key),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.done       (done),
		.found      (found),
		.found_index(found_index)
	);

	lbs_checker #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.entry_index    (entry_index),
		.entry_value    (entry_value),
		.search_key     (search_key),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.done           (done),
		.found          (found),
		.found_index    (found_index),
		.mismatches     (mismatches),
		.lookups_pending(lookups_pending)
	);

	// watchdog: any command or result transfer restarts the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// leaves start high at the transfer edge so back-to-back items need no toggle
	task automatic send_item(logic k, logic [INDEX_W-1:0] idx, logic [KEY_IN_W-1:0] val,
			logic [KEY_IN_W-1:0] key);
		int roll;
		int gap;
		roll = $urandom_range(0, 99);
		gap  = 0;
		if (gaps_on) begin
			if (roll >= 92) begin
				gap = $urandom_range(10, 40);
			end else if (roll >= 60) begin
				gap = $urandom_range(1, 3);
			end
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		kind        <= k;
		entry_index <= idx;
		entry_value <= val;
		search_key  <= key;
		@(posedge clk);
		while (busy) @(posedge clk);
		items_sent++;
	endtask

	task automatic write_entry(int idx, logic [KEY_IN_W-1:0] val);
		loaded_keys[idx[INDEX_W-1:0]] = val;
		send_item(KIND_WRITE, idx[INDEX_W-1:0], val, $urandom);
	endtask

	task automatic issue_search(logic [KEY_IN_W-1:0] key);
		send_item(KIND_SEARCH, INDEX_W'($urandom), $urandom, key);
	endtask

	// wait for every search to answer, then let trailing writes drain
	task automatic quiesce();
		start <= 1'b0;
		@(posedge clk);
		while (lookups_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(logic [COUNT_W-1:0] count, logic signed_sel);
		logic [COUNT_W-1:0] noise;
		noise = COUNT_W'($urandom);
		quiesce();
		write_reg(CFG_ENTRY_COUNT, count);
		// only bit 0 matters, upper bits carry noise
		write_reg(CFG_COMPARE_SIGNED, {noise[COUNT_W-1:1], signed_sel});
		signed_order = signed_sel;
	endtask

	// ascending in the selected order, with runs of duplicates
	task automatic load_sorted(int n);
		logic [KEY_IN_W:0]   rank;
		logic [KEY_IN_W-1:0] max_step;
		int                  i;
		rank = ($urandom_range(0, 3) == 0) ? '0 : {1'b0, $urandom};
		case ($urandom_range(0, 3))
			0:       max_step = 1;
			1:       max_step = 4;
			2:       max_step = 32'hFFFF_FFFF / n;
			default: max_step = $urandom;
		endcase
		for (i = 0; i < n; i++) begin
			write_entry(i, rank[KEY_IN_W-1:0] ^ (signed_order ? SIGN_BIT : '0));
			if ($urandom_range(0, 3) != 0) begin
				rank = rank + $urandom_range(0, max_step);
			end
			if (rank[KEY_IN_W]) begin
				rank = {1'b0, {KEY_IN_W{1'b1}}};
			end
		end
	endtask

	// keys near table contents hit matches and boundaries most often
	task automatic probe_table();
		int                  roll;
		int                  pick;
		logic [KEY_IN_W-1:0] key;
		roll = $urandom_range(0, 99);
		pick = $urandom_range(0, (loaded_count > 0) ? loaded_count - 1 : 0);
		key  = loaded_keys[pick[INDEX_W-1:0]];
		if (roll >= 85) begin
			case ($urandom_range(0, 3))
				0:       key = '0;
				1:       key = '1;
				2:       key = SIGN_BIT;
				default: key = ~SIGN_BIT;
			endcase
		end else if (roll >= 70) begin
			key = $urandom;
		end else if (roll >= 50) begin
			key = $urandom_range(0, 1) ? key + 1 : key - 1;
		end
		issue_search(key);
	endtask

	initial begin : stimulus
		int                 roll;
		int                 i;
		logic [COUNT_W-1:0] count;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table
		issue_search(32'h0000_0000);
		issue_search(32'hFFFF_FFFF);

		// small table with duplicates and the key extremes, unsorted when signed
		write_entry(0, 32'h0000_0000);
		write_entry(1, 32'h0000_0000);
		write_entry(2, 32'h0000_0005);
		write_entry(3, 32'h7FFF_FFFF);
		write_entry(4, 32'h8000_0000);
		write_entry(5, 32'h8000_0000);
		write_entry(6, 32'hFFFF_FFFE);
		write_entry(7, 32'hFFFF_FFFF);
		set_config(8, 1'b0);
		issue_search(32'h0000_0000);
		issue_search(32'h8000_0000);
		issue_search(32'hFFFF_FFFF);
		issue_search(32'h0000_0003);
		issue_search(32'h7FFF_FFFF);
		issue_search(32'hFFFF_FFFE);
		set_config(8, 1'b1);
		issue_search(32'h8000_0000);
		issue_search(32'hFFFF_FFFF);
		issue_search(32'h0000_0000);
		issue_search(32'h7FFF_FFFF);

		// spare register indexes must leave the configuration alone
		quiesce();
		write_reg(CFG_SPARE_A, '1);
		write_reg(CFG_SPARE_B, COUNT_W'($urandom));
		issue_search(32'h0000_0005);
		set_config(1, 1'b0);
		issue_search(32'h0000_0000);

		// full table: every entry written from here on, so any count is safe
		set_config(TABLE_DEPTH, 1'b0);
		load_sorted(TABLE_DEPTH);
		loaded_count = TABLE_DEPTH;
		repeat (20) probe_table();
		set_config('1, 1'b0);
		repeat (10) probe_table();
		set_config(TABLE_DEPTH - 1, 1'b1);
		repeat (10) probe_table();

		while (items_sent < TOTAL_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 10) begin
				count = 0;
			end else if (roll < 75) begin
				count = COUNT_W'($urandom_range(1, 24));
			end else if (roll < 93) begin
				count = COUNT_W'($urandom_range(25, 200));
			end else begin
				count = COUNT_W'($urandom_range(1000, 2047));
			end
			gaps_on = ($urandom_range(0, 3) != 0);
			set_config(count, 1'($urandom_range(0, 1)));
			loaded_count = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
			if (count > 200) begin
				// large counts reuse what is there, a few overwrites break the order
				repeat ($urandom_range(0, 6)) write_entry($urandom_range(0, TABLE_DEPTH - 1),
					$urandom);
			end else if ($urandom_range(0, 9) == 0) begin
				for (i = 0; i < count; i++) write_entry(i, $urandom);
			end else begin
				load_sorted(count);
			end
			repeat ($urandom_range(8, 30)) begin
				if ($urandom_range(0, 19) == 0) begin
					write_entry($urandom_range(0, TABLE_DEPTH - 1), $urandom);
				end else begin
					probe_table();
				end
			end
		end

		quiesce();
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: leftmost_binary_search_core.f
hw/rtl/lbs_pkg.sv
hw/rtl/lbs_front.sv
hw/rtl/lbs_queue.sv
hw/rtl/lbs_back.sv
hw/rtl/leftmost_binary_search_core.sv
dv/lbs_checker.sv
dv/leftmost_binary_search_core_test.sv
